/* src/tpbc_pkg.sv */
// Package for the thermal pixel background classifier.
// Holds the field widths, reset values, level limits, pixel class codes and the history update type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tpbc_pkg;

  // Field widths
  localparam int PIX_W   = 12;
  localparam int BAND_W  = 6;
  localparam int LEVEL_W = 8;
  localparam int IDX_W   = 6;

  // Reset values and level limits
  localparam logic [PIX_W-1:0]   HISTORY_RESET = 12'd100;
  localparam logic [BAND_W-1:0]  BAND_RESET    = 6'd50;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX     = 8'hFF;
  localparam logic [LEVEL_W-1:0] LEVEL_MIN     = 8'h00;

  // Pixel class codes
  typedef enum logic [1:0] {
    CLASS_BAND = 2'd0,
    CLASS_HOT  = 2'd1,
    CLASS_COLD = 2'd2
  } class_t;

  // Frame-end update of the mean history
  typedef struct packed {
    logic             en;
    logic [PIX_W-1:0] mean;
  } hist_upd_t;

endpackage

`default_nettype wire

/* src/tpbc_pixel_if.sv */
// Pixel channel: valid/ready handshake carrying one raw pixel word.
// Depends on tpbc_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface tpbc_pixel_if;
  logic                       valid;
  logic                       ready;
  logic [tpbc_pkg::PIX_W-1:0] pixel_value;

  modport source (output valid, output pixel_value, input ready);
  modport sink   (input valid, input pixel_value, output ready);
endinterface

`default_nettype wire

/* src/tpbc_result_if.sv */
// Result channel: valid/ready handshake carrying one classified pixel word.
// Depends on tpbc_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface tpbc_result_if;
  logic                         valid;
  logic                         ready;
  logic [tpbc_pkg::IDX_W-1:0]   pixel_index;
  logic [tpbc_pkg::LEVEL_W-1:0] green_level;
  logic [tpbc_pkg::LEVEL_W-1:0] blue_level;
  logic [1:0]                   pixel_class;
  logic                         frame_end;

  modport source (output valid, output pixel_index, output green_level,
                  output blue_level, output pixel_class, output frame_end,
                  input ready);
  modport sink   (input valid, input pixel_index, input green_level,
                  input blue_level, input pixel_class, input frame_end,
                  output ready);
endinterface

`default_nettype wire

/* src/thermal_pixel_background_classifier_unit.sv */
// Thermal pixel background classifier, top level.
// Depends on tpbc_pkg, tpbc_pixel_if, tpbc_result_if and tpbc_history.
// Accepts one pixel word per clock and gives one result word per pixel, in
// order, while results are taken. A pixel moves through stage registers
// s1 to s4 to the result register in step with the frame-end chain that runs
// alongside the pixels: frame sum, reciprocal multiply for the frame mean,
// history update, reciprocal multiply for the background. A pixel is
// classified as it enters the result register, against the background
// left by the previous frame's last pixel. The pipeline compresses bubbles,
// so pixels keep entering while a result waits to be taken. A band write
// applies to pixels that reach the result register after it.
`timescale 1ns / 1ps
`default_nettype none

module thermal_pixel_background_classifier_unit #(
  parameter int PIXELS_PER_FRAME = 64,
  parameter int HISTORY_DEPTH    = 10
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  tpbc_pixel_if.sink                       pixels,
  tpbc_result_if.source                    results,
  input  wire logic                        band_wr_en,
  input  wire logic [tpbc_pkg::BAND_W-1:0] band_wr_data
);

  localparam int PIX_W   = tpbc_pkg::PIX_W;
  localparam int IDX_W   = tpbc_pkg::IDX_W;
  localparam int LEVEL_W = tpbc_pkg::LEVEL_W;
  localparam int CNT_W   = $clog2(PIXELS_PER_FRAME);
  localparam int CNT_X   = (CNT_W > IDX_W) ? CNT_W : IDX_W;
  localparam int SUM_W   = PIX_W + CNT_W;
  // exact floor(sum / PIXELS_PER_FRAME) via ceil reciprocal
  localparam int DIV_SH  = SUM_W + CNT_W;
  localparam int MRCP_W  = SUM_W + 2;
  localparam logic [63:0] MeanRecip64 =
    ((64'd1 << DIV_SH) + 64'(PIXELS_PER_FRAME) - 64'd1) / 64'(PIXELS_PER_FRAME);
  localparam logic [MRCP_W-1:0] MeanRecip = MRCP_W'(MeanRecip64);
  // exact floor(total / HISTORY_DEPTH) via ceil reciprocal
  localparam int SLOT_W  = $clog2(HISTORY_DEPTH);
  localparam int TOT_W   = PIX_W + SLOT_W;
  localparam int BG_SH   = TOT_W + SLOT_W;
  localparam int BRCP_W  = TOT_W + 2;
  localparam logic [63:0] BgRecip64 =
    ((64'd1 << BG_SH) + 64'(HISTORY_DEPTH) - 64'd1) / 64'(HISTORY_DEPTH);
  localparam logic [BRCP_W-1:0] BgRecip = BRCP_W'(BgRecip64);
  localparam logic [CNT_W-1:0] CntLast = CNT_W'(PIXELS_PER_FRAME - 1);
  localparam logic [IDX_W-1:0] IdxLast = IDX_W'((PIXELS_PER_FRAME - 1) % 64);
  localparam int CMP_W = PIX_W + 2;

  // ---------------- configuration ----------------
  logic [tpbc_pkg::BAND_W-1:0] band_half_width;

  always_ff @(posedge clk) begin
    if (rst) begin
      band_half_width <= tpbc_pkg::BAND_RESET;
    end else if (band_wr_en) begin
      band_half_width <= band_wr_data;
    end
  end

  // ---------------- pipeline flow control ----------------
  logic v1, v2, v3, v4, out_vld;
  logic en1, en2, en3, en4, en_o;
  logic accept;

  assign en_o   = !out_vld || results.ready;
  assign en4    = !v4 || en_o;
  assign en3    = !v3 || en4;
  assign en2    = !v2 || en3;
  assign en1    = !v1 || en2;
  assign pixels.ready = en1;
  assign accept = pixels.valid && en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1      <= 1'b0;
      v2      <= 1'b0;
      v3      <= 1'b0;
      v4      <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      if (en1)  v1      <= pixels.valid;
      if (en2)  v2      <= v1;
      if (en3)  v3      <= v2;
      if (en4)  v4      <= v3;
      if (en_o) out_vld <= v4;
    end
  end

  // ---------------- frame position and sum ----------------
  logic [CNT_W-1:0] pixel_counter;
  logic [SUM_W-1:0] frame_total;
  logic             last_in;
  logic [SUM_W-1:0] sum_in;
  logic [CNT_X-1:0] cnt_ext;

  assign last_in = (pixel_counter == CntLast);
  assign sum_in  = frame_total + SUM_W'(pixels.pixel_value);
  assign cnt_ext = CNT_X'(pixel_counter);

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_counter <= '0;
      frame_total   <= '0;
    end else if (accept) begin
      pixel_counter <= last_in ? '0 : pixel_counter + CNT_W'(1);
      frame_total   <= last_in ? '0 : sum_in;
    end
  end

  // ---------------- stage registers ----------------
  logic [PIX_W-1:0]        s1_pix, s2_pix, s3_pix, s4_pix;
  logic [IDX_W-1:0]        s1_idx, s2_idx, s3_idx, s4_idx;
  logic                    s1_last, s2_last, s3_last, s4_last;
  logic [SUM_W-1:0]        s1_sum;
  logic [SUM_W+MRCP_W-1:0] s2_prod;
  logic [TOT_W+BRCP_W-1:0] s4_prod;
  logic [TOT_W-1:0]        hist_total;

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix  <= pixels.pixel_value;
      s1_idx  <= cnt_ext[IDX_W-1:0];
      s1_last <= last_in;
      s1_sum  <= sum_in;
    end
    // frame mean product
    if (en2 && v1) begin
      s2_pix  <= s1_pix;
      s2_idx  <= s1_idx;
      s2_last <= s1_last;
      s2_prod <= (SUM_W+MRCP_W)'(s1_sum) * (SUM_W+MRCP_W)'(MeanRecip);
    end
    if (en3 && v2) begin
      s3_pix  <= s2_pix;
      s3_idx  <= s2_idx;
      s3_last <= s2_last;
    end
    // background product from the updated history sum
    if (en4 && v3) begin
      s4_pix  <= s3_pix;
      s4_idx  <= s3_idx;
      s4_last <= s3_last;
      s4_prod <= (TOT_W+BRCP_W)'(hist_total) * (TOT_W+BRCP_W)'(BgRecip);
    end
  end

  // ---------------- mean history ----------------
  tpbc_pkg::hist_upd_t hist_upd;

  assign hist_upd.en   = en3 && v2 && s2_last;
  assign hist_upd.mean = s2_prod[DIV_SH +: PIX_W];

  tpbc_history #(
    .DEPTH (HISTORY_DEPTH)
  ) u_history (
    .clk   (clk),
    .rst   (rst),
    .upd   (hist_upd),
    .total (hist_total)
  );

  // ---------------- background ----------------
  logic [PIX_W-1:0] background_level;
  logic             bg_load;

  assign bg_load = en_o && v4 && s4_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      background_level <= tpbc_pkg::HISTORY_RESET;
    end else if (bg_load) begin
      background_level <= s4_prod[BG_SH +: PIX_W];
    end
  end

  // ---------------- classify ----------------
  logic signed [CMP_W-1:0] pix_s, band_hi, band_lo, band_off;
  logic                    is_hot, is_cold;
  tpbc_pkg::class_t        cls;
  logic [LEVEL_W-1:0]      green, blue;

  assign pix_s    = $signed(CMP_W'(s4_pix));
  assign band_hi  = $signed(CMP_W'(background_level)) + $signed(CMP_W'(band_half_width));
  assign band_lo  = $signed(CMP_W'(background_level)) - $signed(CMP_W'(band_half_width));
  assign band_off = pix_s - band_lo;
  assign is_hot   = pix_s > band_hi;
  assign is_cold  = pix_s < band_lo;

  always_comb begin
    priority if (is_hot) begin
      cls   = tpbc_pkg::CLASS_HOT;
      green = tpbc_pkg::LEVEL_MAX;
      blue  = tpbc_pkg::LEVEL_MIN;
    end else if (is_cold) begin
      cls   = tpbc_pkg::CLASS_COLD;
      green = tpbc_pkg::LEVEL_MIN;
      blue  = tpbc_pkg::LEVEL_MAX;
    end else begin
      // offset within band is at most twice the band half-width, so it fits
      cls   = tpbc_pkg::CLASS_BAND;
      green = {band_off[LEVEL_W-2:0], 1'b0};
      blue  = tpbc_pkg::LEVEL_MAX - green;
    end
  end

  // ---------------- result register ----------------
  logic [IDX_W-1:0]   out_idx;
  logic [LEVEL_W-1:0] out_green, out_blue;
  tpbc_pkg::class_t   out_cls;
  logic               out_last;

  always_ff @(posedge clk) begin
    if (en_o && v4) begin
      out_idx   <= s4_idx;
      out_green <= green;
      out_blue  <= blue;
      out_cls   <= cls;
      out_last  <= s4_last;
    end
  end

  assign results.valid       = out_vld;
  assign results.pixel_index = out_idx;
  assign results.green_level = out_green;
  assign results.blue_level  = out_blue;
  assign results.pixel_class = out_cls;
  assign results.frame_end   = out_last;

  // ---------------- assertions ----------------
  // frame sum restarts after the last pixel of a frame
  a_sum_clear: assert property (@(posedge clk) disable iff (rst)
    (accept && last_in) |=> (frame_total == '0))
    else $error("frame sum not cleared at frame end");

  // background only moves when a frame-end word enters the result register
  a_bg_change: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$stable(background_level)) |-> $past(bg_load))
    else $error("background changed outside frame end");

  // frame end word carries the last position of the frame
  a_end_index: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.frame_end) |-> (results.pixel_index == IdxLast))
    else $error("frame end at wrong pixel index");

  // never two frame ends in flight before the result register
  a_one_end: assert property (@(posedge clk) disable iff (rst)
    $countones({v1 && s1_last, v2 && s2_last, v3 && s3_last, v4 && s4_last}) <= 1)
    else $error("two frame ends in pipeline");

endmodule

`default_nettype wire

/* src/tpbc_history.sv */
// Ring of the last DEPTH frame means and their running sum.
// Depends on tpbc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tpbc_history #(
  parameter int DEPTH = 10
) (
  input  wire logic                                             clk,
  input  wire logic                                             rst,
  input  wire tpbc_pkg::hist_upd_t                              upd,
  output logic [tpbc_pkg::PIX_W+$clog2(DEPTH)-1:0]              total
);

  localparam int SLOT_W = $clog2(DEPTH);
  localparam int TOT_W  = tpbc_pkg::PIX_W + SLOT_W;
  localparam logic [TOT_W-1:0] TotalReset =
    TOT_W'(DEPTH * int'(tpbc_pkg::HISTORY_RESET));
  localparam logic [TOT_W-1:0] TotalMax = TOT_W'(DEPTH * 4095);
  localparam logic [SLOT_W-1:0] SlotLast = SLOT_W'(DEPTH - 1);

  logic [tpbc_pkg::PIX_W-1:0] hist [DEPTH];
  logic [SLOT_W-1:0]          oldest_slot;
  logic [TOT_W-1:0]           history_total;
  logic [TOT_W-1:0]           history_total_next;

  // oldest entry out, new mean in
  assign history_total_next = history_total - TOT_W'(hist[oldest_slot]) + TOT_W'(upd.mean);
  assign total = history_total;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        hist[i] <= tpbc_pkg::HISTORY_RESET;
      end
      history_total <= TotalReset;
      oldest_slot   <= '0;
    end else if (upd.en) begin
      hist[oldest_slot] <= upd.mean;
      history_total     <= history_total_next;
      oldest_slot       <= (oldest_slot == SlotLast) ? '0 : oldest_slot + SLOT_W'(1);
    end
  end

  // Ring pointer never leaves the stored entries
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    oldest_slot <= SlotLast)
    else $error("history slot out of range");

  // Running sum bounded by DEPTH full-scale means
  a_total_range: assert property (@(posedge clk) disable iff (rst)
    history_total <= TotalMax)
    else $error("history total overflow");

  // Sum follows each update exactly
  a_total_update: assert property (@(posedge clk) disable iff (rst)
    upd.en |=> history_total == $past(history_total_next))
    else $error("history total not updated");

endmodule

`default_nettype wire
